// ===== rtl/hpp_pkg.sv =====
// Shared types and constants for the hex polynomial parser.
// Holds the beat structs, the parser phase enum and the status codes.
// No dependencies.
package hpp_pkg;

    // Default bound on the number of coefficients (first power must stay below it).
    localparam int unsigned MAX_TERMS_DEF = 32'd65536;

    typedef enum logic [2:0] {
        PH_START,
        PH_COEFF,
        PH_CARET,
        PH_POWER,
        PH_PLUS,
        PH_SPACE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_POWER    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] character;
        logic       is_end;
    } char_t;

    typedef struct packed {
        logic [15:0] term_power;
        logic [63:0] term_value;
        logic        has_term;
        logic        final_res;
        status_t     status;
        logic [16:0] coeff_total;
        logic        all_zero;
    } term_t;

endpackage

// ===== rtl/hpp_core.sv =====
// Parser state and per-character decision logic of the hex polynomial parser.
// One character is consumed per step; a result is produced combinationally.
// Depends on hpp_pkg.
module hpp_core #(
    parameter int unsigned MAX_TERMS = hpp_pkg::MAX_TERMS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  hpp_pkg::char_t item,
    output hpp_pkg::term_t result,
    output logic           result_vld
);

    localparam int unsigned PW = $clog2(MAX_TERMS + 1);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_TERMS);
    localparam logic [PW+3:0] MAX_W = (PW + 4)'(MAX_TERMS);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] off;
        begin
            off = 8'h00;
            if (c >= CH_0 && c <= CH_9)
            begin
                off = c - CH_0;
                hex_decode = {1'b1, off[3:0]};
            end
            else if (c >= CH_UA && c <= CH_UF)
            begin
                off = c - CH_UA + 8'd10;
                hex_decode = {1'b1, off[3:0]};
            end
            else if (c >= CH_LA && c <= CH_LF)
            begin
                off = c - CH_LA + 8'd10;
                hex_decode = {1'b1, off[3:0]};
            end
            else
            begin
                hex_decode = 5'b0_0000;
            end
        end
    endfunction

    hpp_pkg::phase_t  phase_reg, phase_next;
    hpp_pkg::status_t err_reg, err_next;
    logic [63:0]      coeff_reg, coeff_next;
    logic             ovf_reg, ovf_next;
    logic [PW-1:0]    power_reg, power_next;
    logic [PW-1:0]    prev_reg, prev_next;
    logic [PW-1:0]    fppo_reg, fppo_next;
    logic             nz_reg, nz_next;

    logic [7:0]    c;
    logic [4:0]    hex;
    logic          is_dec;
    logic [7:0]    dec_off;
    logic [PW+3:0] pw_wide;
    logic [PW-1:0] pw_sat;
    logic          fin_req;
    logic          fin_ok;
    logic [PW-1:0] fin_pow;
    logic [PW-1:0] fppo_upd;
    logic          nz_upd;
    logic          bad_sep;
    logic [63:0]   coeff_base;

    // Shared decode of the current character against the current phase.
    always_comb
    begin
        c       = item.character;
        hex     = hex_decode(c);
        is_dec  = (c >= CH_0) && (c <= CH_9);
        dec_off = c - CH_0;
        pw_wide = {1'b0, power_reg, 3'b000} + {3'b000, power_reg, 1'b0}
                + {{PW{1'b0}}, dec_off[3:0]};
        pw_sat  = (pw_wide > MAX_W) ? MAX_P : pw_wide[PW-1:0];

        // A term closes on the space after its power, or on the end beat.
        if (item.is_end)
        begin
            fin_req = (phase_reg == hpp_pkg::PH_COEFF) || (phase_reg == hpp_pkg::PH_POWER);
            fin_pow = (phase_reg == hpp_pkg::PH_POWER) ? power_reg : '0;
        end
        else
        begin
            fin_req = (phase_reg == hpp_pkg::PH_POWER) && (c == CH_SPACE);
            fin_pow = power_reg;
        end
        fin_ok   = fin_req && (fin_pow < prev_reg);
        fppo_upd = (fin_ok && (fppo_reg == '0)) ? (fin_pow + PW'(1)) : fppo_reg;
        nz_upd   = nz_reg || (fin_ok && (coeff_reg != 64'd0));
        bad_sep  = (phase_reg == hpp_pkg::PH_CARET) || (phase_reg == hpp_pkg::PH_PLUS)
                || (phase_reg == hpp_pkg::PH_SPACE);
        coeff_base = (phase_reg == hpp_pkg::PH_START) ? 64'd0 : coeff_reg;
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        coeff_next = coeff_reg;
        ovf_next   = ovf_reg;
        power_next = power_reg;
        prev_next  = prev_reg;
        fppo_next  = fppo_reg;
        nz_next    = nz_reg;
        if (item.is_end)
        begin
            // The end beat always returns the parser to its idle state.
            phase_next = hpp_pkg::PH_START;
            err_next   = hpp_pkg::ST_OK;
            coeff_next = 64'd0;
            ovf_next   = 1'b0;
            power_next = '0;
            prev_next  = MAX_P;
            fppo_next  = '0;
            nz_next    = 1'b0;
        end
        else
        begin
            case (phase_reg)
                hpp_pkg::PH_START, hpp_pkg::PH_COEFF:
                begin
                    if (hex[4])
                    begin
                        if (coeff_base[63:60] != 4'd0)
                        begin
                            ovf_next = 1'b1;
                        end
                        coeff_next = {coeff_base[59:0], hex[3:0]};
                        phase_next = hpp_pkg::PH_COEFF;
                    end
                    else if ((phase_reg == hpp_pkg::PH_COEFF) && (c == CH_X))
                    begin
                        phase_next = hpp_pkg::PH_CARET;
                    end
                    else
                    begin
                        phase_next = hpp_pkg::PH_ERROR;
                        err_next   = hpp_pkg::ST_SYNTAX;
                    end
                end
                hpp_pkg::PH_CARET:
                begin
                    if (c == CH_CARET)
                    begin
                        power_next = '0;
                        phase_next = hpp_pkg::PH_POWER;
                    end
                    else
                    begin
                        phase_next = hpp_pkg::PH_ERROR;
                        err_next   = hpp_pkg::ST_SYNTAX;
                    end
                end
                hpp_pkg::PH_POWER:
                begin
                    if (is_dec)
                    begin
                        power_next = pw_sat;
                    end
                    else if (c == CH_SPACE)
                    begin
                        if (fin_ok)
                        begin
                            prev_next  = fin_pow;
                            fppo_next  = fppo_upd;
                            nz_next    = nz_upd;
                            phase_next = hpp_pkg::PH_PLUS;
                        end
                        else
                        begin
                            phase_next = hpp_pkg::PH_ERROR;
                            err_next   = hpp_pkg::ST_POWER;
                        end
                    end
                    else
                    begin
                        phase_next = hpp_pkg::PH_ERROR;
                        err_next   = hpp_pkg::ST_SYNTAX;
                    end
                end
                hpp_pkg::PH_PLUS:
                begin
                    if (c == CH_PLUS)
                    begin
                        phase_next = hpp_pkg::PH_SPACE;
                    end
                    else
                    begin
                        phase_next = hpp_pkg::PH_ERROR;
                        err_next   = hpp_pkg::ST_SYNTAX;
                    end
                end
                hpp_pkg::PH_SPACE:
                begin
                    if (c == CH_SPACE)
                    begin
                        phase_next = hpp_pkg::PH_START;
                        coeff_next = 64'd0;
                    end
                    else
                    begin
                        phase_next = hpp_pkg::PH_ERROR;
                        err_next   = hpp_pkg::ST_SYNTAX;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result of the current character.
    always_comb
    begin
        result     = '0;
        result_vld = item.is_end || fin_ok;
        if (fin_ok)
        begin
            result.term_power = 16'(fin_pow);
            result.term_value = coeff_reg;
            result.has_term   = 1'b1;
        end
        if (item.is_end)
        begin
            result.final_res = 1'b1;
            if (phase_reg == hpp_pkg::PH_ERROR)
            begin
                result.status = err_reg;
            end
            else if (fin_req && !fin_ok)
            begin
                result.status = hpp_pkg::ST_POWER;
            end
            else if (bad_sep)
            begin
                result.status = hpp_pkg::ST_SYNTAX;
            end
            else if (ovf_reg)
            begin
                result.status = hpp_pkg::ST_OVERFLOW;
            end
            else
            begin
                result.status      = hpp_pkg::ST_OK;
                result.coeff_total = 17'(fppo_upd);
                result.all_zero    = !nz_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hpp_pkg::PH_START;
            err_reg   <= hpp_pkg::ST_OK;
            coeff_reg <= 64'd0;
            ovf_reg   <= 1'b0;
            power_reg <= '0;
            prev_reg  <= MAX_P;
            fppo_reg  <= '0;
            nz_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            coeff_reg <= coeff_next;
            ovf_reg   <= ovf_next;
            power_reg <= power_next;
            prev_reg  <= prev_next;
            fppo_reg  <= fppo_next;
            nz_reg    <= nz_next;
        end
    end

endmodule

// ===== rtl/hex_polynomial_parser_top.sv =====
// Top level of the hex polynomial parser: input register, parser core, result register.
// Depends on hpp_pkg and hpp_core.
//
//  channel | valid      | stall      | data                     | beat
//  --------+------------+------------+--------------------------+---------------------------
//  input   | char_valid | char_stall | char_data  (hpp_pkg::char_t) | one character or the end
//  result  | term_valid | term_stall | term_data  (hpp_pkg::term_t) | one finished term / final
//
// The block takes one character beat per cycle while char_stall is low. A beat is held in the
// input register and is parsed on its way into the result register, from which its result
// is presented on term_valid and term_data and held there until it is taken.
// The only loop is the parser state update, which is one short step per character.
// Reset clears the parser to wait for the first coefficient digit. A stalled result
// holds the result register, which stalls the input once the input register is also full.
module hex_polynomial_parser_top #(
    parameter int unsigned MAX_TERMS = hpp_pkg::MAX_TERMS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_stall,
    input  hpp_pkg::char_t char_data,
    output logic           term_valid,
    input  logic           term_stall,
    output hpp_pkg::term_t term_data
);

    // Input register: holds one accepted character beat.
    logic           in_vld_reg, in_vld_next;
    hpp_pkg::char_t in_data_reg;

    // Result register: holds one result beat until it is taken.
    logic           out_vld_reg, out_vld_next;
    hpp_pkg::term_t out_data_reg;

    logic           can_load;
    logic           advance;
    logic           char_accept;
    hpp_pkg::term_t core_result;
    logic           core_result_vld;

    // The result register can take a new beat when it is empty or being drained.
    assign can_load    = !out_vld_reg || !term_stall;
    assign advance     = in_vld_reg && can_load;
    assign char_stall  = in_vld_reg && !can_load;
    assign char_accept = char_valid && !char_stall;

    assign term_valid = out_vld_reg;
    assign term_data  = out_data_reg;

    hpp_core #(
        .MAX_TERMS (MAX_TERMS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (in_data_reg),
        .result     (core_result),
        .result_vld (core_result_vld)
    );

    always_comb
    begin
        if (char_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (can_load)
        begin
            out_vld_next = advance && core_result_vld;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            in_data_reg <= char_data;
        end
        if (advance && core_result_vld)
        begin
            out_data_reg <= core_result;
        end
    end

`ifndef ASSERT_OFF
    // A failed text never reports a coefficient count or an all-zero flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (term_valid && term_data.final_res && (term_data.status != hpp_pkg::ST_OK))
        |-> ((term_data.coeff_total == 17'd0) && !term_data.all_zero))
    else $error("failed text reports coefficient count or all-zero flag");

    // Only a finished term produces a result before the end beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (term_valid && !term_data.final_res)
        |-> (term_data.has_term && (term_data.status == hpp_pkg::ST_OK)))
    else $error("non-final result without a term");

    // A character held back by a full result register stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_data_reg)))
    else $error("held character lost from input register");
`endif

endmodule
